>>> rtl/pec_pkg.sv
// Shared types, constants and gain tables for the peak envelope compressor.
`default_nettype none

package pec_pkg;

    // Gain table resolution: each table has 2^GAIN_TABLE_BITS entries
    localparam int GAIN_TABLE_BITS = 8;
    localparam int TAB_SIZE        = 1 << GAIN_TABLE_BITS;

    // Fixed field widths
    localparam int SAMPLE_W = 24;              // Q1.23 samples, levels, gain
    localparam int COEFF_W  = 16;              // Q0.16 smoothing coefficients
    localparam int LOG_W    = 21;              // Q16 log2, integer part up to 23
    localparam int LOGTAB_W = 17;              // log2 fraction entry, up to 1.0
    localparam int MUL_W    = 25;              // shared multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic [SAMPLE_W-1:0] ONE_Q23 = 24'd8388608;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATIO     = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_ATTACK    = 2'd2;
    localparam logic [1:0] CFG_RELEASE   = 2'd3;

    // Ratio select codes
    localparam logic [2:0] SEL_BYPASS = 3'd0;
    localparam logic [2:0] SEL_R4     = 3'd1;
    localparam logic [2:0] SEL_R8     = 3'd2;
    localparam logic [2:0] SEL_R12    = 3'd3;
    localparam logic [2:0] SEL_R20    = 3'd4;

    // Per ratio: R-1, R/2, and ceil(2^26/divisor) for the division after >>2
    localparam logic [4:0]       RATIO_M1   [5] = '{5'd0, 5'd3, 5'd7, 5'd11, 5'd19};
    localparam logic [3:0]       RATIO_HALF [5] = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd10};
    localparam logic [MUL_W-1:0] DIV_RECIP  [5] =
        '{25'd0, 25'd0, 25'd0, 25'd22369622, 25'd13421773};
    localparam int RECIP_SHIFT = 26;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BYPASS,
        S_ENV_A,
        S_ENV_B,
        S_ENV_SUM,
        S_LOG_E,
        S_LOG_T,
        S_OVER,
        S_DIV,
        S_DIV_Q,
        S_GAIN,
        S_SCALE_L,
        S_SCALE_R,
        S_DONE
    } state_t;

    typedef logic [LOGTAB_W-1:0] log_tab_t [TAB_SIZE];
    typedef logic [SAMPLE_W-1:0] exp_tab_t [TAB_SIZE];

    // Bitwise integer square root, 64-bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^B) in Q16, by repeated squaring in Q1.30
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] y;
        logic [17:0] r;
        for (int i = 0; i < TAB_SIZE; i++) begin
            y = 64'(TAB_SIZE + i) << (30 - GAIN_TABLE_BITS);
            r = '0;
            for (int k = 0; k < 17; k++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    y = y >> 1;
                    r = {r[16:0], 1'b1};
                end
                else begin
                    r = {r[16:0], 1'b0};
                end
            end
            t[i] = LOGTAB_W'((r + 18'd1) >> 1);
        end
        return t;
    endfunction

    // 2^(-i/2^B) in Q1.23, product of square-root chain roots in Q0.30
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] roots [GAIN_TABLE_BITS+1];
        logic [63:0] v;
        roots[0] = 64'd1 << 29;
        for (int b = 1; b <= GAIN_TABLE_BITS; b++) begin
            roots[b] = isqrt64(roots[b-1] << 30);
        end
        for (int i = 0; i < TAB_SIZE; i++) begin
            v = 64'd1 << 30;
            for (int b = 1; b <= GAIN_TABLE_BITS; b++) begin
                if (((i >> (GAIN_TABLE_BITS - b)) & 1) != 0) begin
                    v = (v * roots[b] + (64'd1 << 29)) >> 30;
                end
            end
            t[i] = SAMPLE_W'((v + 64'd64) >> 7);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

>>> rtl/pec_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module pec_mul (
    input  wire logic                          clk,
    input  wire logic [pec_pkg::MUL_W-1:0]     a,
    input  wire logic [pec_pkg::MUL_W-1:0]     b,
    output logic      [pec_pkg::PROD_W-1:0]    p
);

    logic [pec_pkg::PROD_W-1:0] p_reg;
    logic [pec_pkg::PROD_W-1:0] p_next;

    always_comb
    begin
        p_next = pec_pkg::PROD_W'(a) * pec_pkg::PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/pec_log2.sv
// Shared log2 unit: Q16 logarithm of a 24-bit magnitude, registered result.
`default_nettype none

module pec_log2 (
    input  wire logic                          clk,
    input  wire logic [pec_pkg::SAMPLE_W-1:0]  x,
    output logic      [pec_pkg::LOG_W-1:0]     q
);

    logic [4:0]                          msb_pos;
    logic [pec_pkg::SAMPLE_W-1:0]        norm;
    logic [pec_pkg::GAIN_TABLE_BITS-1:0] idx;
    logic [pec_pkg::LOG_W-1:0]           q_reg;
    logic [pec_pkg::LOG_W-1:0]           q_next;

    // Position of the leading one (input is at least 1)
    always_comb
    begin
        msb_pos = '0;
        for (int i = 1; i < pec_pkg::SAMPLE_W; i++) begin
            if (x[i]) begin
                msb_pos = 5'(i);
            end
        end
    end

    // Normalize, take the bits below the leading one as the table index
    always_comb
    begin
        norm   = x << (5'd23 - msb_pos);
        idx    = norm[22 -: pec_pkg::GAIN_TABLE_BITS];
        q_next = (pec_pkg::LOG_W'(msb_pos) << 16)
               + pec_pkg::LOG_W'(pec_pkg::LOG_TAB[idx]);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

>>> rtl/peak_envelope_compressor.sv
// Top level of the peak envelope compressor: config, sequencer and datapath.
//
// One stereo frame is processed at a time. For ratios 12 and 20 the division by the
// ratio takes a pass through the shared multiplier; for ratios 4 and 8 it is a shift.
// When the envelope stays at or below the threshold, the log, division and gain steps
// are skipped, and in bypass the frame is copied to the output. A new frame is taken
// once the block is back in its idle state. The steps follow the passes through the
// single shared 25x25 multiplier: envelope update, exponent scaling, division by 12 or
// 20, and one pass per channel for the gain. Two passes through the shared log2 unit
// lie between the envelope update and the exponent scaling.
// in_stall is high while a frame is in work. Results sit in an output register, so
// the next frame is taken while a finished one waits. The block holds in its last
// step only if the output register is still full. Configuration writes are always
// ready and must only be issued while the block is idle.
`default_nettype none

module peak_envelope_compressor (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    // input frames
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [23:0]  left_in,
    input  wire logic signed [23:0]  right_in,
    // output frames
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [23:0]       left_out,
    output logic signed [23:0]       right_out,
    output logic                     reducing
);

    localparam int SW = pec_pkg::SAMPLE_W;
    localparam int CW = pec_pkg::COEFF_W;
    localparam int LW = pec_pkg::LOG_W;
    localparam int MW = pec_pkg::MUL_W;
    localparam int PW = pec_pkg::PROD_W;
    localparam int B  = pec_pkg::GAIN_TABLE_BITS;

    // Control and configuration state
    pec_pkg::state_t state_reg, state_next;
    logic [2:0]      ratio_sel_reg;
    logic [SW-1:0]   thr_reg;
    logic [CW-1:0]   attack_reg;
    logic [CW-1:0]   release_reg;
    logic [SW-1:0]   env_reg, env_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    logic [SW-1:0]   l_reg, l_next;
    logic [SW-1:0]   r_reg, r_next;
    logic [40:0]     acc_reg, acc_next;
    logic [LW-1:0]   le_reg, le_next;
    logic [LW-1:0]   d_reg, d_next;
    logic [SW-1:0]   gain_reg, gain_next;
    logic            red_reg, red_next;
    logic [SW-1:0]   lres_reg, lres_next;
    logic [SW-1:0]   left_out_reg, left_out_next;
    logic [SW-1:0]   right_out_reg, right_out_next;
    logic            reducing_reg, reducing_next;

    // Shared units
    logic [MW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   mul_p;
    logic [SW-1:0]   log_x;
    logic [LW-1:0]   log_q;

    // Derived values
    logic            in_xfer, cfg_xfer, out_free;
    logic [2:0]      sel_eff;
    logic [SW-1:0]   thr_eff;
    logic [SW-1:0]   mag_l, mag_r, level;
    logic [CW-1:0]   coeff;
    logic [CW:0]     coeff_inv;
    logic [40:0]     env_sum;
    logic [SW-1:0]   env_new;
    logic [LW-1:0]   over;
    logic [25:0]     num;
    logic [4:0]      q_shift;
    logic [B-1:0]    exp_idx;
    logic [SW-1:0]   exp_val;
    logic [SW:0]     gain_round;
    logic [SW-1:0]   gain_calc;
    logic [PW-1:0]   prod_round;
    logic [SW-1:0]   scaled;

    pec_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pec_log2 u_log2 (
        .clk (clk),
        .x   (log_x),
        .q   (log_q)
    );

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != pec_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ratio_sel_reg <= pec_pkg::SEL_BYPASS;
            thr_reg       <= 24'd4194304;
            attack_reg    <= 16'd65000;
            release_reg   <= 16'd65500;
        end
        else if (cfg_xfer) begin
            unique case (cfg_index)
                pec_pkg::CFG_RATIO:     ratio_sel_reg <= cfg_data[2:0];
                pec_pkg::CFG_THRESHOLD: thr_reg       <= cfg_data;
                pec_pkg::CFG_ATTACK:    attack_reg    <= cfg_data[CW-1:0];
                pec_pkg::CFG_RELEASE:   release_reg   <= cfg_data[CW-1:0];
                default:                ;
            endcase
        end
    end

    // Clamped settings
    assign sel_eff = (ratio_sel_reg > pec_pkg::SEL_R20) ? pec_pkg::SEL_R20 : ratio_sel_reg;
    assign thr_eff = (thr_reg == '0) ? SW'(1) : thr_reg;

    // Peak level and smoothing coefficient
    always_comb
    begin
        mag_l     = l_reg[SW-1] ? SW'(0) - l_reg : l_reg;
        mag_r     = r_reg[SW-1] ? SW'(0) - r_reg : r_reg;
        level     = (mag_l > mag_r) ? mag_l : mag_r;
        coeff     = (level > env_reg) ? attack_reg : release_reg;
        coeff_inv = 17'd65536 - {1'b0, coeff};
    end

    // Envelope sum, exponent and division numerator
    always_comb
    begin
        env_sum = acc_reg + 41'(mul_p) + 41'd32768;
        env_new = env_sum[39:16];
        over    = (le_reg > log_q) ? le_reg - log_q : '0;
        num     = 26'(mul_p) + 26'(pec_pkg::RATIO_HALF[sel_eff]);
    end

    // Gain from the exponent: table value shifted by the integer part, rounded
    always_comb
    begin
        q_shift    = d_reg[LW-1:16];
        exp_idx    = d_reg[15 -: B];
        exp_val    = pec_pkg::EXP_TAB[exp_idx];
        gain_round = '0;
        if (q_shift >= 5'd24) begin
            gain_calc = '0;
        end
        else if (q_shift == 5'd0) begin
            gain_calc = exp_val;
        end
        else begin
            gain_round = ({1'b0, exp_val} + ((SW+1)'(1) << (q_shift - 5'd1))) >> q_shift;
            gain_calc  = gain_round[SW-1:0];
        end
    end

    // Rounded magnitude times gain
    always_comb
    begin
        prod_round = mul_p + (PW'(1) << 22);
        scaled     = prod_round[46:23];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pec_pkg::S_IDLE:
            begin
                if (in_xfer) begin
                    state_next = (sel_eff == pec_pkg::SEL_BYPASS) ? pec_pkg::S_BYPASS
                                                                  : pec_pkg::S_ENV_A;
                end
            end
            pec_pkg::S_BYPASS:
            begin
                if (out_free) begin
                    state_next = pec_pkg::S_IDLE;
                end
            end
            pec_pkg::S_ENV_A:   state_next = pec_pkg::S_ENV_B;
            pec_pkg::S_ENV_B:   state_next = pec_pkg::S_ENV_SUM;
            pec_pkg::S_ENV_SUM:
            begin
                state_next = (env_new > thr_eff) ? pec_pkg::S_LOG_E : pec_pkg::S_SCALE_L;
            end
            pec_pkg::S_LOG_E:   state_next = pec_pkg::S_LOG_T;
            pec_pkg::S_LOG_T:   state_next = pec_pkg::S_OVER;
            pec_pkg::S_OVER:    state_next = pec_pkg::S_DIV;
            pec_pkg::S_DIV:
            begin
                case (sel_eff) inside
                    pec_pkg::SEL_R4, pec_pkg::SEL_R8: state_next = pec_pkg::S_GAIN;
                    default:                          state_next = pec_pkg::S_DIV_Q;
                endcase
            end
            pec_pkg::S_DIV_Q:   state_next = pec_pkg::S_GAIN;
            pec_pkg::S_GAIN:    state_next = pec_pkg::S_SCALE_L;
            pec_pkg::S_SCALE_L: state_next = pec_pkg::S_SCALE_R;
            pec_pkg::S_SCALE_R: state_next = pec_pkg::S_DONE;
            pec_pkg::S_DONE:
            begin
                if (out_free) begin
                    state_next = pec_pkg::S_IDLE;
                end
            end
            default:            state_next = pec_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and register updates
    always_comb
    begin
        mul_a          = '0;
        mul_b          = '0;
        log_x          = env_reg;
        env_next       = env_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        le_next        = le_reg;
        d_next         = d_reg;
        gain_next      = gain_reg;
        red_next       = red_reg;
        lres_next      = lres_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        reducing_next  = reducing_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            pec_pkg::S_IDLE:
            begin
                if (in_xfer) begin
                    l_next = left_in;
                    r_next = right_in;
                end
            end
            pec_pkg::S_BYPASS:
            begin
                if (out_free) begin
                    left_out_next  = l_reg;
                    right_out_next = r_reg;
                    reducing_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            pec_pkg::S_ENV_A:
            begin
                mul_a = MW'(coeff);
                mul_b = MW'(env_reg);
            end
            pec_pkg::S_ENV_B:
            begin
                mul_a    = MW'(coeff_inv);
                mul_b    = MW'(level);
                acc_next = mul_p[40:0];
            end
            pec_pkg::S_ENV_SUM:
            begin
                env_next  = env_new;
                gain_next = pec_pkg::ONE_Q23;
                red_next  = 1'b0;
            end
            pec_pkg::S_LOG_E:
            begin
                log_x = env_reg;
            end
            pec_pkg::S_LOG_T:
            begin
                log_x   = thr_eff;
                le_next = log_q;
            end
            pec_pkg::S_OVER:
            begin
                mul_a = MW'(over);
                mul_b = MW'(pec_pkg::RATIO_M1[sel_eff]);
            end
            pec_pkg::S_DIV:
            begin
                case (sel_eff)
                    pec_pkg::SEL_R4: d_next = LW'(num >> 2);
                    pec_pkg::SEL_R8: d_next = LW'(num >> 3);
                    default:
                    begin
                        mul_a = MW'(num[25:2]);
                        mul_b = pec_pkg::DIV_RECIP[sel_eff];
                    end
                endcase
            end
            pec_pkg::S_DIV_Q:
            begin
                d_next = LW'(mul_p >> pec_pkg::RECIP_SHIFT);
            end
            pec_pkg::S_GAIN:
            begin
                gain_next = gain_calc;
                red_next  = (gain_calc < pec_pkg::ONE_Q23);
            end
            pec_pkg::S_SCALE_L:
            begin
                mul_a = MW'(mag_l);
                mul_b = MW'(gain_reg);
            end
            pec_pkg::S_SCALE_R:
            begin
                mul_a     = MW'(mag_r);
                mul_b     = MW'(gain_reg);
                lres_next = l_reg[SW-1] ? SW'(0) - scaled : scaled;
            end
            pec_pkg::S_DONE:
            begin
                // keep the right channel product steady while waiting
                mul_a = MW'(mag_r);
                mul_b = MW'(gain_reg);
                if (out_free) begin
                    left_out_next  = lres_reg;
                    right_out_next = r_reg[SW-1] ? SW'(0) - scaled : scaled;
                    reducing_next  = red_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= pec_pkg::S_IDLE;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        le_reg        <= le_next;
        d_reg         <= d_next;
        gain_reg      <= gain_next;
        red_reg       <= red_next;
        lres_reg      <= lres_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        reducing_reg  <= reducing_next;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign reducing  = reducing_reg;

endmodule

`default_nettype wire

>>> tb/pec_frame_checker.sv
// Frame checker for the peak envelope compressor: predicts every frame and compares results.
module pec_frame_checker
    import pec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [23:0] left_in,
    input  logic signed [23:0] right_in,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] left_out,
    input  logic signed [23:0] right_out,
    input  logic               reducing,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        reducing;
    } frame_t;

    // Predicted register file and envelope follower state
    logic [2:0]  ratio_sel;
    logic [23:0] thresh;
    logic [15:0] atk;
    logic [15:0] rel;
    logic [23:0] env_level;

    // log2 fraction (Q16) and exp2 gain (Q1.23) lookups
    logic [16:0] log_frac [TAB_SIZE];
    logic [23:0] exp_gain [TAB_SIZE];

    frame_t frames_q [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] one;
        n    = n_in;
        root = '0;
        one  = 64'd1 << 62;
        while (one > n)
            one = one >> 2;
        while (one != 0)
        begin
            if (n >= root + one)
            begin
                n    = n - (root + one);
                root = (root >> 1) + one;
            end
            else
            begin
                root = root >> 1;
            end
            one = one >> 2;
        end
        return root;
    endfunction

    // Build both lookups: log by repeated squaring, exp by a chain of square roots
    initial
    begin : build_tables
        logic [63:0] roots [GAIN_TABLE_BITS+1];
        logic [63:0] y;
        logic [63:0] v;
        logic [31:0] bits;
        roots[0] = 64'd1 << 29;
        for (int b = 1; b <= GAIN_TABLE_BITS; b++)
            roots[b] = int_sqrt(roots[b-1] << 30);
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            y    = 64'(TAB_SIZE + i) << (30 - GAIN_TABLE_BITS);
            bits = '0;
            for (int k = 0; k < 17; k++)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31))
                begin
                    y    = y >> 1;
                    bits = (bits << 1) | 32'd1;
                end
                else
                begin
                    bits = bits << 1;
                end
            end
            log_frac[i] = 17'((bits + 32'd1) >> 1);
            v = 64'd1 << 30;
            for (int b = 1; b <= GAIN_TABLE_BITS; b++)
                if (i[GAIN_TABLE_BITS - b])
                    v = (v * roots[b] + (64'd1 << 29)) >> 30;
            exp_gain[i] = 24'((v + 64'd64) >> 7);
        end
    end

    function automatic logic [24:0] magnitude(input logic [23:0] x);
        logic [24:0] m;
        m = {1'b0, x};
        return x[23] ? 25'h1000000 - m : m;
    endfunction

    // Q16 log2: integer part from the leading one, fraction from the lookup
    function automatic logic [31:0] log2_q16(input logic [23:0] x);
        int unsigned p;
        logic [23:0] m;
        int unsigned idx;
        p = 0;
        while (p < 23 && (x >> (p + 1)) != 0)
            p++;
        m   = x << (23 - p);
        idx = 32'(m >> (23 - GAIN_TABLE_BITS)) & (TAB_SIZE - 1);
        return (p << 16) + 32'(log_frac[idx]);
    endfunction

    // Magnitude times gain, rounded, sign put back (half away from zero)
    function automatic logic [23:0] apply_gain(input logic [23:0] x, input logic [63:0] gain);
        logic [63:0] prod;
        prod = ({39'd0, magnitude(x)} * gain + (64'd1 << 22)) >> 23;
        if (x[23])
            prod = -prod;
        return prod[23:0];
    endfunction

    // One frame through the compressor; advances the envelope
    function automatic frame_t compress_frame(input logic [23:0] lraw, input logic [23:0] rraw);
        frame_t      res;
        logic [2:0]  sel;
        logic [63:0] ratio;
        logic [63:0] peak;
        logic [63:0] coeff;
        logic [63:0] acc;
        logic [63:0] over;
        logic [63:0] dexp;
        logic [63:0] gain;
        logic [23:0] thr;
        logic [31:0] le;
        logic [31:0] lt;
        int unsigned q;
        int unsigned fidx;
        res.left     = lraw;
        res.right    = rraw;
        res.reducing = 1'b0;
        sel = (ratio_sel > SEL_R20) ? SEL_R20 : ratio_sel;
        if (sel == SEL_BYPASS)
            return res;
        case (sel)
            SEL_R4:  ratio = 64'd4;
            SEL_R8:  ratio = 64'd8;
            SEL_R12: ratio = 64'd12;
            default: ratio = 64'd20;
        endcase

        // Peak detector and one-pole envelope
        peak  = 64'((magnitude(lraw) > magnitude(rraw)) ? magnitude(lraw) : magnitude(rraw));
        coeff = 64'((peak > 64'(env_level)) ? atk : rel);
        acc   = coeff * 64'(env_level) + (64'd65536 - coeff) * peak + 64'd32768;
        env_level = acc[39:16];

        // Gain computer in the log domain
        thr  = (thresh == '0) ? 24'd1 : thresh;
        gain = 64'(ONE_Q23);
        if (env_level > thr)
        begin
            le   = log2_q16(env_level);
            lt   = log2_q16(thr);
            over = (le > lt) ? 64'(le - lt) : 64'd0;
            dexp = (over * (ratio - 1) + ratio / 2) / ratio;
            q    = 32'(dexp >> 16);
            fidx = 32'(dexp[15:0] >> (16 - GAIN_TABLE_BITS));
            if (q >= 24)
                gain = '0;
            else if (q == 0)
                gain = 64'(exp_gain[fidx]);
            else
                gain = (64'(exp_gain[fidx]) + (64'd1 << (q - 1))) >> q;
            res.reducing = (gain < 64'(ONE_Q23));
        end
        res.left  = apply_gain(lraw, gain);
        res.right = apply_gain(rraw, gain);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_t want;
        if (!rst_n)
        begin
            ratio_sel = SEL_BYPASS;
            thresh    = 24'd4194304;
            atk       = 16'd65000;
            rel       = 16'd65500;
            env_level = '0;
            frames_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RATIO:     ratio_sel = cfg_data[2:0];
                    CFG_THRESHOLD: thresh    = cfg_data;
                    CFG_ATTACK:    atk       = cfg_data[15:0];
                    CFG_RELEASE:   rel       = cfg_data[15:0];
                    default: ;
                endcase
            end

            // result transfer
            if (out_valid && !out_stall)
            begin
                if (frames_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with no frame outstanding, left %0d right %0d",
                             $time, left_out, right_out);
                end
                else
                begin
                    want = frames_q.pop_front();
                    check_field("left_out", want.left, left_out);
                    check_field("right_out", want.right, right_out);
                    check_field("reducing", {23'd0, want.reducing}, {23'd0, reducing});
                end
            end

            // input transfer
            if (in_valid && !in_stall)
                frames_q.push_back(compress_frame(left_in, right_in));

            pending <= frames_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the peak envelope compressor testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pec_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 9;
    localparam int PHASE_FRAMES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = CFG_RATIO;
    logic [23:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic signed [23:0] left_in   = '0;
    logic signed [23:0] right_in  = '0;
    logic               out_stall = 1'b0;
    wire                cfg_ready;
    wire                in_stall;
    wire                out_valid;
    wire signed [23:0]  left_out;
    wire signed [23:0]  right_out;
    wire                reducing;

    int errors;
    int pending;
    int cycle_count = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left   = 0;
    bit calm        = 1'b0;

    peak_envelope_compressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .reducing  (reducing)
    );

    pec_frame_checker frame_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .reducing  (reducing),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("peak_envelope_compressor verification failed");
            $finish;
        end
    end

    // Output side: long hold-off on request, otherwise random stalls outside the calm phase
    always @(posedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Register write; cfg_valid stays high when another write follows
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [2:0] ratio, input logic [23:0] thr,
                                  input logic [15:0] attack, input logic [15:0] decay);
        write_reg(CFG_RATIO, {21'd0, ratio}, 1'b0);
        write_reg(CFG_THRESHOLD, thr, 1'b0);
        write_reg(CFG_ATTACK, {8'd0, attack}, 1'b0);
        write_reg(CFG_RELEASE, {8'd0, decay}, 1'b1);
    endtask

    // One frame transfer, with random idle cycles ahead of it
    task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every predicted frame has come back and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly shaped by the current loudness, now and then full scale, zero or fully random
    function automatic logic [23:0] draw_sample(input int unsigned shift);
        logic [23:0] s;
        case ($urandom_range(31))
            0:          s = 24'h7FFFFF;
            1:          s = 24'h800000;
            2:          s = '0;
            3, 4, 5, 6: s = 24'($urandom);
            default:
            begin
                s = {1'b0, 23'($urandom)} >> shift;
                if ($urandom_range(1) != 0)
                    s = -s;
            end
        endcase
        return s;
    endfunction

    function automatic logic [15:0] draw_coeff();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(60000, 65535));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [2:0]  ratio;
        logic [23:0] thr;
        int          sent;
        int          seg_len;
        int unsigned shift;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Registers at reset: bypass, full-scale extremes pass through
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'hFFFFFF, 24'h000001);
        drain();

        // Only the ratio written: default threshold and coefficients in use
        write_reg(CFG_RATIO, {21'd0, SEL_R20}, 1'b1);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        drain();

        // Threshold zero, instant attack, slowest release
        apply_settings(SEL_R20, 24'd0, 16'd0, 16'hFFFF);
        send_frame(24'h800000, 24'h000000);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h000001, 24'hFFFFFF);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        drain();

        // Ratio code above the last one, threshold above full scale
        apply_settings(3'd7, 24'hFFFFFF, 16'hFFFF, 16'd0);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h000000);
        drain();

        // Smallest threshold, envelope tracks the peak exactly
        apply_settings(SEL_R4, 24'd1, 16'd0, 16'd0);
        send_frame(24'h000002, 24'h000000);
        send_frame(24'h400000, 24'hC00000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000001, 24'h000001);
        drain();

        // Threshold at full scale: envelope may reach it but never exceed it
        apply_settings(SEL_R8, 24'd8388608, 16'd0, 16'd0);
        send_frame(24'h800000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h800001);
        drain();

        apply_settings(SEL_R12, 24'h000800, 16'd32768, 16'd65000);
        send_frame(24'h7FFFFF, 24'h000000);
        send_frame(24'h123456, 24'hEDCBAA);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h000800, 24'hFFF800);
        drain();

        // Random phases: fresh settings, then loud and quiet passages
        for (int ph = 0; ph < PHASES; ph++)
        begin
            ratio = ($urandom_range(3) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
            case ($urandom_range(7))
                0:       thr = 24'd1;
                1:       thr = 24'd8388608;
                2:       thr = 24'($urandom);
                3:       thr = 24'd0;
                default: thr = 24'($urandom_range(1, 8388608)) >> $urandom_range(0, 6);
            endcase
            apply_settings(ratio, thr, draw_coeff(), draw_coeff());
            calm <= (ph == 4);

            sent = 0;
            while (sent < PHASE_FRAMES)
            begin
                seg_len = $urandom_range(4, 30);
                shift   = $urandom_range(0, 14);
                for (int k = 0; k < seg_len && sent < PHASE_FRAMES; k++)
                begin
                    send_frame(draw_sample(shift), draw_sample(shift));
                    sent++;
                    // long receiver hold-off while frames keep coming
                    if (sent == PHASE_FRAMES / 2 && (ph == 2 || ph == 6))
                        hold_ticket <= hold_ticket + 1;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("peak_envelope_compressor verification clean");
        else
            $display("peak_envelope_compressor verification failed");
        $finish;
    end

endmodule
